// ===== hdl/qaa_pkg.sv =====
// shared types, action codes and rounding helpers for the quaternion attitude alu
// no dependencies
package qaa_pkg;

    localparam int unsigned QW = 32;
    localparam int unsigned PW = 64;
    localparam int unsigned SW = 66;

    localparam logic [1:0] ACT_PROD = 2'd0;
    localparam logic [1:0] ACT_RATE = 2'd1;
    localparam logic [1:0] ACT_MAT  = 2'd2;

    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef enum logic [1:0] {
        SH28,
        SH29,
        SH30
    } t_shift;

    // widen a product and apply its sign
    function automatic logic signed [SW-1:0] term(input logic signed [PW-1:0] p,
                                                  input logic neg);
        logic signed [SW-1:0] w;
        w = {{(SW-PW){p[PW-1]}}, p};
        return neg ? -w : w;
    endfunction

    // half of one output lsb, for round half up
    function automatic logic signed [SW-1:0] half(input t_shift s);
        logic signed [SW-1:0] h;
        case (s)
            SH28:    h = SW'(1) << 27;
            SH30:    h = SW'(1) << 29;
            default: h = SW'(1) << 28;
        endcase
        return h;
    endfunction

endpackage

// ===== hdl/qaa_round.sv =====
// scale, round and saturate one accumulated component to q3.29
// depends on qaa_pkg
module qaa_round (
    input  logic signed [qaa_pkg::SW-1:0] i_sum,
    input  qaa_pkg::t_shift               i_shift,
    output logic signed [qaa_pkg::QW-1:0] o_value,
    output logic                          o_sat
);
    import qaa_pkg::*;

    logic signed [SW-1:0] shifted;

    // half lsb was already added upstream, so this is a floor
    always_comb begin
        unique case (i_shift)
            SH28:    shifted = i_sum >>> 28;
            SH29:    shifted = i_sum >>> 29;
            SH30:    shifted = i_sum >>> 30;
            default: shifted = i_sum >>> 29;
        endcase
    end

    always_comb begin
        o_sat   = 1'b0;
        o_value = shifted[QW-1:0];
        if (shifted[SW-1] && !(&shifted[SW-1:QW-1])) begin
            o_sat   = 1'b1;
            o_value = {1'b1, {(QW-1){1'b0}}};
        end else if (!shifted[SW-1] && (|shifted[SW-1:QW-1])) begin
            o_sat   = 1'b1;
            o_value = {1'b0, {(QW-1){1'b1}}};
        end
    end

endmodule

// ===== hdl/quaternion_attitude_alu_top.sv =====
// a result strobe follows the accepting edge through the product, sum and output registers;
// a matrix request gives its three rows on consecutive cycles
// throughput: one product or rate request per cycle; a matrix request holds busy
// while the operand stage steps to the next row, so no new request is taken before its last row
// reset clears the valid bits and the row counter only; the receiver cannot stall and results are never held
module quaternion_attitude_alu_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic signed [qaa_pkg::QW-1:0] i_a_w,
    input  logic signed [qaa_pkg::QW-1:0] i_a_x,
    input  logic signed [qaa_pkg::QW-1:0] i_a_y,
    input  logic signed [qaa_pkg::QW-1:0] i_a_z,
    input  logic signed [qaa_pkg::QW-1:0] i_b_w,
    input  logic signed [qaa_pkg::QW-1:0] i_b_x,
    input  logic signed [qaa_pkg::QW-1:0] i_b_y,
    input  logic signed [qaa_pkg::QW-1:0] i_b_z,
    output logic                          o_valid,
    output logic signed [qaa_pkg::QW-1:0] o_result_0,
    output logic signed [qaa_pkg::QW-1:0] o_result_1,
    output logic signed [qaa_pkg::QW-1:0] o_result_2,
    output logic signed [qaa_pkg::QW-1:0] o_result_3,
    output logic [1:0]                    o_row_number,
    output logic                          o_saturated,
    output logic                          o_last_of_run
);
    import qaa_pkg::*;

    // stage 1: operands
    logic                 r_s1_valid;
    logic [1:0]           r_s1_act;
    logic [1:0]           r_s1_row;
    logic signed [QW-1:0] r_s1_a [4];
    logic signed [QW-1:0] r_s1_b [4];

    // stage 2: products
    logic                 r_s2_valid;
    logic [1:0]           r_s2_act;
    logic [1:0]           r_s2_row;
    logic signed [PW-1:0] r_p [4][4];

    // stage 3: sums
    logic                 r_s3_valid;
    logic [1:0]           r_s3_row;
    logic                 r_s3_last;
    logic signed [SW-1:0] r_sum [4];
    t_shift               r_shift [4];

    logic                 accept;
    logic signed [QW-1:0] c_op [4];
    logic signed [SW-1:0] n_sum [4];
    t_shift               n_shift [4];
    logic signed [QW-1:0] rnd_val [4];
    logic [3:0]           rnd_sat;

    assign busy   = r_s1_valid && (r_s1_act == ACT_MAT) && (r_s1_row != ROW_LAST);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_row   <= '0;
        end else if (accept) begin
            r_s1_valid <= (i_action == ACT_PROD) || (i_action == ACT_RATE)
                          || (i_action == ACT_MAT);
            r_s1_row   <= '0;
        end else if (busy) begin
            r_s1_row <= r_s1_row + 2'd1;
        end else begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_act  <= i_action;
            r_s1_a[0] <= i_a_w;
            r_s1_a[1] <= i_a_x;
            r_s1_a[2] <= i_a_y;
            r_s1_a[3] <= i_a_z;
            r_s1_b[0] <= i_b_w;
            r_s1_b[1] <= i_b_x;
            r_s1_b[2] <= i_b_y;
            r_s1_b[3] <= i_b_z;
        end
    end

    // the matrix squares a against itself
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            c_op[j] = (r_s1_act == ACT_MAT) ? r_s1_a[j] : r_s1_b[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_act <= r_s1_act;
        r_s2_row <= r_s1_row;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                r_p[i][j] <= r_s1_a[i] * c_op[j];
            end
        end
    end

    // signed term selection per action and matrix row
    always_comb begin
        logic signed [SW-1:0] t [4][4];
        for (int k = 0; k < 4; k++) begin
            for (int m = 0; m < 4; m++) begin
                t[k][m] = '0;
            end
            n_shift[k] = SH29;
        end
        case (r_s2_act)
            ACT_PROD: begin
                t[0][0] = term(r_p[0][0], 1'b0); t[0][1] = term(r_p[1][1], 1'b1);
                t[0][2] = term(r_p[2][2], 1'b1); t[0][3] = term(r_p[3][3], 1'b1);
                t[1][0] = term(r_p[0][1], 1'b0); t[1][1] = term(r_p[1][0], 1'b0);
                t[1][2] = term(r_p[2][3], 1'b0); t[1][3] = term(r_p[3][2], 1'b1);
                t[2][0] = term(r_p[0][2], 1'b0); t[2][1] = term(r_p[1][3], 1'b1);
                t[2][2] = term(r_p[2][0], 1'b0); t[2][3] = term(r_p[3][1], 1'b0);
                t[3][0] = term(r_p[0][3], 1'b0); t[3][1] = term(r_p[1][2], 1'b0);
                t[3][2] = term(r_p[2][1], 1'b1); t[3][3] = term(r_p[3][0], 1'b0);
            end
            ACT_RATE: begin
                for (int k = 0; k < 4; k++) begin
                    n_shift[k] = SH30;
                end
                t[0][0] = term(r_p[1][1], 1'b1); t[0][1] = term(r_p[2][2], 1'b1);
                t[0][2] = term(r_p[3][3], 1'b1);
                t[1][0] = term(r_p[0][1], 1'b0); t[1][1] = term(r_p[3][2], 1'b1);
                t[1][2] = term(r_p[2][3], 1'b0);
                t[2][0] = term(r_p[3][1], 1'b0); t[2][1] = term(r_p[0][2], 1'b0);
                t[2][2] = term(r_p[1][3], 1'b1);
                t[3][0] = term(r_p[2][1], 1'b1); t[3][1] = term(r_p[1][2], 1'b0);
                t[3][2] = term(r_p[0][3], 1'b0);
            end
            default: begin
                // matrix row; off-diagonal entries carry the factor two in the shift
                n_shift[0] = SH28;
                n_shift[1] = SH28;
                n_shift[2] = SH28;
                case (r_s2_row)
                    2'd0: begin
                        n_shift[0] = SH29;
                        t[0][0] = term(r_p[0][0], 1'b0); t[0][1] = term(r_p[1][1], 1'b0);
                        t[0][2] = term(r_p[2][2], 1'b1); t[0][3] = term(r_p[3][3], 1'b1);
                        t[1][0] = term(r_p[1][2], 1'b0); t[1][1] = term(r_p[0][3], 1'b0);
                        t[2][0] = term(r_p[1][3], 1'b0); t[2][1] = term(r_p[0][2], 1'b1);
                    end
                    2'd1: begin
                        n_shift[1] = SH29;
                        t[0][0] = term(r_p[1][2], 1'b0); t[0][1] = term(r_p[0][3], 1'b1);
                        t[1][0] = term(r_p[0][0], 1'b0); t[1][1] = term(r_p[1][1], 1'b1);
                        t[1][2] = term(r_p[2][2], 1'b0); t[1][3] = term(r_p[3][3], 1'b1);
                        t[2][0] = term(r_p[2][3], 1'b0); t[2][1] = term(r_p[0][1], 1'b0);
                    end
                    default: begin
                        n_shift[2] = SH29;
                        t[0][0] = term(r_p[1][3], 1'b0); t[0][1] = term(r_p[0][2], 1'b0);
                        t[1][0] = term(r_p[2][3], 1'b0); t[1][1] = term(r_p[0][1], 1'b1);
                        t[2][0] = term(r_p[0][0], 1'b0); t[2][1] = term(r_p[1][1], 1'b1);
                        t[2][2] = term(r_p[2][2], 1'b1); t[2][3] = term(r_p[3][3], 1'b0);
                    end
                endcase
            end
        endcase
        for (int k = 0; k < 4; k++) begin
            n_sum[k] = t[k][0] + t[k][1] + t[k][2] + t[k][3] + half(n_shift[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_row  <= (r_s2_act == ACT_MAT) ? r_s2_row : 2'd0;
        r_s3_last <= (r_s2_act != ACT_MAT) || (r_s2_row == ROW_LAST);
        for (int k = 0; k < 4; k++) begin
            r_sum[k]   <= n_sum[k];
            r_shift[k] <= n_shift[k];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_round
        qaa_round u_round (
            .i_sum   (r_sum[k]),
            .i_shift (r_shift[k]),
            .o_value (rnd_val[k]),
            .o_sat   (rnd_sat[k])
        );
    end

    // stage 4: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_0    <= rnd_val[0];
        o_result_1    <= rnd_val[1];
        o_result_2    <= rnd_val[2];
        o_result_3    <= rnd_val[3];
        o_saturated   <= |rnd_sat;
        o_row_number  <= r_s3_row;
        o_last_of_run <= r_s3_last;
    end

`ifndef SYNTH
    a_row_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> r_s1_valid && (r_s1_row == $past(r_s1_row) + 2'd1))
        else $error("matrix row did not advance");

    a_rows_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |=> o_valid && (o_row_number == $past(o_row_number) + 2'd1))
        else $error("matrix rows not consecutive");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !$past(accept))
        else $error("request taken while busy");
`endif

endmodule

// ===== dv/quaternion_attitude_alu_checker.sv =====
// checker for the quaternion attitude alu: predicts results of accepted requests
// and compares them with the result strobe; depends on qaa_pkg
module quaternion_attitude_alu_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [1:0]                    i_action,
    input  logic signed [qaa_pkg::QW-1:0] i_a_w,
    input  logic signed [qaa_pkg::QW-1:0] i_a_x,
    input  logic signed [qaa_pkg::QW-1:0] i_a_y,
    input  logic signed [qaa_pkg::QW-1:0] i_a_z,
    input  logic signed [qaa_pkg::QW-1:0] i_b_w,
    input  logic signed [qaa_pkg::QW-1:0] i_b_x,
    input  logic signed [qaa_pkg::QW-1:0] i_b_y,
    input  logic signed [qaa_pkg::QW-1:0] i_b_z,
    input  logic                          o_valid,
    input  logic signed [qaa_pkg::QW-1:0] o_result_0,
    input  logic signed [qaa_pkg::QW-1:0] o_result_1,
    input  logic signed [qaa_pkg::QW-1:0] o_result_2,
    input  logic signed [qaa_pkg::QW-1:0] o_result_3,
    input  logic [1:0]                    o_row_number,
    input  logic                          o_saturated,
    input  logic                          o_last_of_run,
    output int                            o_errors,
    output int                            o_pending
);
    import qaa_pkg::*;

    typedef struct {
        logic signed [31:0] c [4];
        logic [1:0]         row;
        logic               sat;
        logic               last;
    } t_quat_out;

    t_quat_out quat_expected [$];
    int        err_cnt = 0;

    assign o_errors  = err_cnt;
    assign o_pending = quat_expected.size();

    // sum of four exact products, rounded half up at bit s, clamped to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [65:0] p0,
                                                     input logic signed [65:0] p1,
                                                     input logic signed [65:0] p2,
                                                     input logic signed [65:0] p3,
                                                     input int s, inout logic sat);
        logic signed [67:0] acc;
        acc = p0 + p1 + p2 + p3 + (68'sd1 <<< (s - 1));
        acc = acc >>> s;
        if (acc > 68'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (acc < -68'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return acc[31:0];
    endfunction

    function automatic logic signed [65:0] mul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
        logic signed [65:0] xx, yy;
        xx = x;
        yy = y;
        return xx * yy;
    endfunction

    task automatic predict_request();
        t_quat_out r;
        logic signed [31:0] a0, a1, a2, a3, b0, b1, b2, b3;
        logic signed [65:0] s00, s11, s22, s33, s01, s02, s03, s12, s13, s23;
        a0 = i_a_w; a1 = i_a_x; a2 = i_a_y; a3 = i_a_z;
        b0 = i_b_w; b1 = i_b_x; b2 = i_b_y; b3 = i_b_z;
        r.sat = 1'b0;
        r.row = 2'd0;
        r.last = 1'b1;
        case (i_action)
            ACT_PROD: begin
                r.c[0] = round_sat(mul(a0, b0), -mul(a1, b1), -mul(a2, b2), -mul(a3, b3),
                                   29, r.sat);
                r.c[1] = round_sat(mul(a0, b1), mul(a1, b0), mul(a2, b3), -mul(a3, b2),
                                   29, r.sat);
                r.c[2] = round_sat(mul(a0, b2), -mul(a1, b3), mul(a2, b0), mul(a3, b1),
                                   29, r.sat);
                r.c[3] = round_sat(mul(a0, b3), mul(a1, b2), -mul(a2, b1), mul(a3, b0),
                                   29, r.sat);
                quat_expected.push_back(r);
            end
            ACT_RATE: begin
                r.c[0] = round_sat(-mul(a1, b1), -mul(a2, b2), -mul(a3, b3), 0, 30, r.sat);
                r.c[1] = round_sat(mul(a0, b1), -mul(a3, b2), mul(a2, b3), 0, 30, r.sat);
                r.c[2] = round_sat(mul(a3, b1), mul(a0, b2), -mul(a1, b3), 0, 30, r.sat);
                r.c[3] = round_sat(-mul(a2, b1), mul(a1, b2), mul(a0, b3), 0, 30, r.sat);
                quat_expected.push_back(r);
            end
            ACT_MAT: begin
                s00 = mul(a0, a0); s11 = mul(a1, a1); s22 = mul(a2, a2); s33 = mul(a3, a3);
                s01 = mul(a0, a1); s02 = mul(a0, a2); s03 = mul(a0, a3);
                s12 = mul(a1, a2); s13 = mul(a1, a3); s23 = mul(a2, a3);
                r.c[3] = '0;
                r.last = 1'b0;
                r.c[0] = round_sat(s00, s11, -s22, -s33, 29, r.sat);
                r.c[1] = round_sat(s12, s03, 0, 0, 28, r.sat);
                r.c[2] = round_sat(s13, -s02, 0, 0, 28, r.sat);
                quat_expected.push_back(r);
                r.sat = 1'b0;
                r.row = 2'd1;
                r.c[0] = round_sat(s12, -s03, 0, 0, 28, r.sat);
                r.c[1] = round_sat(s00, -s11, s22, -s33, 29, r.sat);
                r.c[2] = round_sat(s23, s01, 0, 0, 28, r.sat);
                quat_expected.push_back(r);
                r.sat = 1'b0;
                r.row = ROW_LAST;
                r.last = 1'b1;
                r.c[0] = round_sat(s13, s02, 0, 0, 28, r.sat);
                r.c[1] = round_sat(s23, -s01, 0, 0, 28, r.sat);
                r.c[2] = round_sat(s00, -s11, -s22, s33, 29, r.sat);
                quat_expected.push_back(r);
            end
            default: ;  // unused selector gives nothing
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_quat_out e;
        if (i_rst_n && o_valid) begin
            if (quat_expected.size() == 0) begin
                $error("result strobe with no request outstanding");
                err_cnt++;
            end else begin
                e = quat_expected.pop_front();
                check_field("result_0", e.c[0], o_result_0);
                check_field("result_1", e.c[1], o_result_1);
                check_field("result_2", e.c[2], o_result_2);
                check_field("result_3", e.c[3], o_result_3);
                check_field("row_number", 32'(e.row), 32'(o_row_number));
                check_field("saturated", 32'(e.sat), 32'(o_saturated));
                check_field("last_of_run", 32'(e.last), 32'(o_last_of_run));
            end
        end
        if (i_rst_n && start && !busy)
            predict_request();
    end

endmodule

// ===== dv/quaternion_attitude_alu_top_tb.sv =====
// testbench top for quaternion_attitude_alu_top: drives directed and random requests
// with idle phases; depends on qaa_pkg and quaternion_attitude_alu_checker
module quaternion_attitude_alu_top_tb;
    import qaa_pkg::*;

    localparam int MAX_CYCLES = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        i_action = ACT_PROD;
    logic signed [31:0] i_a_w = '0, i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_w = '0, i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic              o_valid;
    logic signed [31:0] o_result_0, o_result_1, o_result_2, o_result_3;
    logic [1:0]        o_row_number;
    logic              o_saturated, o_last_of_run;
    int                errors, pending;
    int                cycle_cnt = 0;
    int                idle_pct = 0;

    quaternion_attitude_alu_top dut (.*);
    quaternion_attitude_alu_checker chk (.*, .o_errors(errors), .o_pending(pending));

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > MAX_CYCLES) begin
            $display("** quaternion_attitude_alu_top: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return 32'h20000000;   // +1.0
            3: return 32'he0000000;   // -1.0
            4: return '0;
            5, 6: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h40000000)) - 32'sh20000000);
        endcase
    endfunction

    // present one request and hold it until accepted
    task automatic send_request(input logic [1:0] act, input logic [31:0] aw, ax, ay, az,
                                input logic [31:0] bw, bx, by, bz);
        while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_a_w <= aw; i_a_x <= ax; i_a_y <= ay; i_a_z <= az;
        i_b_w <= bw; i_b_x <= bx; i_b_y <= by; i_b_z <= bz;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        logic [1:0] act;
        act = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_request(act, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                     pick_comp(), pick_comp(), pick_comp(), pick_comp());
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        logic [1:0] act;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: identity, extremes, unit rotations, every action and the unused one
        for (int k = 0; k < 4; k++) begin
            act = 2'(k);
            send_request(act, 32'h20000000, 0, 0, 0, 32'h20000000, 0, 0, 0);
            send_request(act, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
            send_request(act, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                         32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
            send_request(act, 32'h16a09e66, 32'h16a09e66, 0, 0,
                         32'hffffffff, 32'h00000001, 32'hffffffff, 32'h00000001);
            send_request(act, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                         32'h00000001, 32'h00000001, 32'h00000001, 32'h00000001);
        end
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 84;
                2: idle_pct = 18;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 90; n++) send_random();
            if (ph == 1) drain();   // sender waits for every result outstanding
        end

        drain();
        if (errors == 0)
            $display("** quaternion_attitude_alu_top: PASSED **");
        else
            $display("** quaternion_attitude_alu_top: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/qaa_pkg.sv
hdl/qaa_round.sv
hdl/quaternion_attitude_alu_top.sv
dv/quaternion_attitude_alu_checker.sv
dv/quaternion_attitude_alu_top_tb.sv
